### hdl/lgs_pkg.sv
// shared types and constants for the life grid generation step unit
// request codes, sequencer states and the control word broadcast to the row cells
// no dependencies
`default_nettype none

package lgs_pkg;

    localparam int CELL_COL_W = 6;
    localparam int CELL_ROW_W = 6;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_READ    = 2'd1,
        REQ_ADVANCE = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_STEP = 1'b1
    } state_t;

    // control word seen by every row cell
    typedef struct packed {
        logic                  clear;
        logic                  shift;
        logic                  wr_en;
        logic                  wr_val;
        logic [CELL_ROW_W-1:0] row;
        logic [CELL_COL_W-1:0] col;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### hdl/lgs_next_row.sv
// b3/s23 rule for one full grid row, all columns in parallel, wrapping at the edges
// depends on nothing but its inputs
`default_nettype none

module lgs_next_row #(
    parameter int GRID_COLS = 64
) (
    input  wire logic [GRID_COLS-1:0] above,
    input  wire logic [GRID_COLS-1:0] here,
    input  wire logic [GRID_COLS-1:0] below,
    output logic      [GRID_COLS-1:0] result
);

    for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
        localparam int L = (c == 0) ? GRID_COLS - 1 : c - 1;
        localparam int R = (c == GRID_COLS - 1) ? 0 : c + 1;
        logic [3:0] count;

        always_comb
        begin
            count = {3'b000, above[L]} + {3'b000, above[c]} + {3'b000, above[R]}
                  + {3'b000, here[L]}  + {3'b000, here[R]}
                  + {3'b000, below[L]} + {3'b000, below[c]} + {3'b000, below[R]};
            result[c] = (count == 4'd3) || (here[c] && (count == 4'd2));
        end
    end

endmodule

`default_nettype wire

### hdl/lgs_row_cell.sv
// one grid row held in a chain cell: shift from neighbor, clear, single-bit write, bit read
// depends on lgs_pkg
`default_nettype none

module lgs_row_cell
    import lgs_pkg::*;
#(
    parameter int GRID_COLS = 64,
    parameter int ROW_INDEX = 0
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cell_ctrl_t           ctrl,
    input  wire logic [GRID_COLS-1:0] shift_in,
    output logic      [GRID_COLS-1:0] row_q,
    output logic                      rd_bit
);

    localparam int COL_IDX_W = $clog2(GRID_COLS);

    logic [GRID_COLS-1:0] row_reg;
    logic [GRID_COLS-1:0] row_next;
    logic [COL_IDX_W-1:0] col_idx;
    logic                 hit;

    assign col_idx = ctrl.col[COL_IDX_W-1:0];
    assign hit     = (int'(ctrl.row) == ROW_INDEX);

    always_comb
    begin
        row_next = row_reg;
        if (ctrl.clear)
        begin
            row_next = '0;
        end
        else if (ctrl.shift)
        begin
            row_next = shift_in;
        end
        else if (ctrl.wr_en && hit)
        begin
            row_next[col_idx] = ctrl.wr_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    assign row_q  = row_reg;
    assign rd_bit = hit && row_reg[col_idx];

endmodule

`default_nettype wire

### hdl/life_grid_generation_step_unit.sv
// top level of the life grid generation step unit: request decode, advance sequencer,
// chain of row cells and output register
// depends on lgs_pkg, lgs_row_cell, lgs_next_row
`default_nettype none

// channel  | dir | signals                         | fields
// s_axis   | in  | tvalid tready tdata[15:0] tuser | request word
// m_axis   | out | tvalid tready tdata[7:0]  tuser | completion word
//
// write, read and clear are done when accepted; the completion word shows up the next cycle
// after an advance is accepted the row chain rotates one row per cycle
// through the single rule unit at its head, then the advance completion word is loaded
// reset clears every cell flop at once, so the grid is all dead right after reset
// a new request is taken only while no advance runs and the output register is free
// or being emptied in the same cycle; m_axis_tready low simply holds the completion word

module life_grid_generation_step_unit
    import lgs_pkg::*;
#(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // cell_col[5:0], cell_row[11:6], write_alive[12]
    input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // read_alive[0]
    output logic [1:0]       m_axis_tuser   // done_type[1:0]
);

    localparam int STEP_W = $clog2(GRID_ROWS);

    // request fields
    req_t                  req_type;
    logic [CELL_COL_W-1:0] cell_col;
    logic [CELL_ROW_W-1:0] cell_row;
    logic                  write_alive;
    logic                  s_acc;
    logic                  on_grid;

    assign req_type    = req_t'(s_axis_tuser);
    assign cell_col    = s_axis_tdata[5:0];
    assign cell_row    = s_axis_tdata[11:6];
    assign write_alive = s_axis_tdata[12];
    assign s_acc       = s_axis_tvalid && s_axis_tready;
    // rows past the grid never match a cell, so only the column needs checking
    assign on_grid     = (int'(cell_col) < GRID_COLS);

    // sequencer
    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                step_last;

    // old copies of the row above and of row 0 while the chain rotates
    logic [GRID_COLS-1:0] old_prev_reg;
    logic [GRID_COLS-1:0] old_prev_next;
    logic [GRID_COLS-1:0] old_first_reg;
    logic [GRID_COLS-1:0] old_first_next;

    // output register
    logic out_valid_reg;
    logic out_valid_next;
    req_t out_type_reg;
    req_t out_type_next;
    logic out_bit_reg;
    logic out_bit_next;
    logic out_free;

    // cell chain
    cell_ctrl_t           ctrl;
    logic [GRID_COLS-1:0] row_q [GRID_ROWS];
    logic [GRID_ROWS-1:0] rd_bits;
    logic [GRID_COLS-1:0] below_row;
    logic [GRID_COLS-1:0] new_row;

    assign step_last = (step_reg == STEP_W'(GRID_ROWS - 1));
    assign out_free  = !out_valid_reg || m_axis_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && (req_type == REQ_ADVANCE))
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (step_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready  = 1'b0;
        step_next      = step_reg;
        old_prev_next  = old_prev_reg;
        old_first_next = old_first_reg;
        ctrl.clear     = 1'b0;
        ctrl.shift     = 1'b0;
        ctrl.wr_en     = 1'b0;
        ctrl.wr_val    = write_alive;
        ctrl.row       = cell_row;
        ctrl.col       = cell_col;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = out_free;
                step_next     = '0;
                ctrl.clear    = s_acc && (req_type == REQ_CLEAR);
                ctrl.wr_en    = s_acc && (req_type == REQ_WRITE) && on_grid;
                if (s_acc && (req_type == REQ_ADVANCE))
                begin
                    old_prev_next  = row_q[GRID_ROWS-1];
                    old_first_next = row_q[0];
                end
            end
            ST_STEP:
            begin
                ctrl.shift    = 1'b1;
                step_next     = step_reg + STEP_W'(1);
                old_prev_next = row_q[0];
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // completion word
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_type_next  = out_type_reg;
        out_bit_next   = out_bit_reg;
        if (s_acc && (req_type != REQ_ADVANCE))
        begin
            out_valid_next = 1'b1;
            out_type_next  = req_type;
            out_bit_next   = (req_type == REQ_READ) && on_grid && (|rd_bits);
        end
        else if ((state_reg == ST_STEP) && step_last)
        begin
            out_valid_next = 1'b1;
            out_type_next  = REQ_ADVANCE;
            out_bit_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_type_reg  <= REQ_WRITE;
            out_bit_reg   <= 1'b0;
            old_prev_reg  <= '0;
            old_first_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            out_type_reg  <= out_type_next;
            out_bit_reg   <= out_bit_next;
            old_prev_reg  <= old_prev_next;
            old_first_reg <= old_first_next;
        end
    end

    // rule unit at the head of the chain; on the last step row 1 already holds new row 0
    assign below_row = step_last ? old_first_reg : row_q[1];

    lgs_next_row #(
        .GRID_COLS (GRID_COLS)
    ) u_next_row (
        .above  (old_prev_reg),
        .here   (row_q[0]),
        .below  (below_row),
        .result (new_row)
    );

    // row chain: each cell takes the row of the next higher-numbered cell, the tail takes the new row
    for (genvar i = 0; i < GRID_ROWS; i++) begin : g_cell
        logic [GRID_COLS-1:0] shift_src;

        if (i == GRID_ROWS - 1) begin : g_tail
            assign shift_src = new_row;
        end
        else begin : g_link
            assign shift_src = row_q[i+1];
        end

        lgs_row_cell #(
            .GRID_COLS (GRID_COLS),
            .ROW_INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .shift_in (shift_src),
            .row_q    (row_q[i]),
            .rd_bit   (rd_bits[i])
        );
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0000000, out_bit_reg};
    assign m_axis_tuser  = out_type_reg;

    // an accepted advance starts the row walk
    a_adv_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && (req_type == REQ_ADVANCE)) |=> (state_reg == ST_STEP) && (step_reg == '0))
        else $error("advance did not start the row walk");

    // the end of the row walk delivers an advance completion
    a_adv_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_STEP) && step_last) |=>
            (m_axis_tvalid && (m_axis_tuser == REQ_ADVANCE) && (state_reg == ST_IDLE)))
        else $error("row walk ended without an advance completion");

    // only a read completion may carry a live bit
    a_bit_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != REQ_READ)) |-> !m_axis_tdata[0])
        else $error("live bit on a completion that is not a read");

    // no request is taken while rows are being shifted
    a_no_take_mid_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift |-> !s_acc && !ctrl.wr_en && !ctrl.clear)
        else $error("request taken during the row walk");

endmodule

`default_nettype wire

### tb/sv/tb_life_grid_generation_step_unit.sv
// self-checking testbench for life_grid_generation_step_unit
// holds its own copy of the toroidal grid, predicts every completion word and compares
// depends on lgs_pkg and life_grid_generation_step_unit
`timescale 1ns / 100ps

module tb_life_grid_generation_step_unit;
    import lgs_pkg::*;

    localparam int COLS        = 64;
    localparam int ROWS        = 64;
    localparam int ITEMS       = 1050;
    // last stretch of the run goes without any idling
    localparam int CALM_ITEMS  = 150;
    // an advance plus the longest gap on both sides, taken many times over
    localparam int QUIET_LIMIT = 20 * (ROWS + 14);
    localparam int DRAIN_WAIT  = ROWS + 10;

    // what one completion word should carry
    typedef struct packed {
        req_t kind;
        logic alive;
    } completion_t;

    // grid predictor plus queue of completions still to come
    class life_scoreboard;
        logic [COLS-1:0] grid [ROWS];
        completion_t     awaited [$];
        int              mismatches;

        function new();
            foreach (grid[r])
                grid[r] = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // b3/s23 with wrap on top, bottom, left and right edges, each cell from the old copy of the grid
        function void step_generation();
            logic [COLS-1:0] old [ROWS];
            int              count;
            old = grid;
            for (int r = 0; r < ROWS; r++)
            begin
                for (int c = 0; c < COLS; c++)
                begin
                    count = 0;
                    for (int dr = -1; dr <= 1; dr++)
                    begin
                        for (int dc = -1; dc <= 1; dc++)
                        begin
                            if (dr != 0 || dc != 0)
                                count += int'(old[(r + dr + ROWS) % ROWS][(c + dc + COLS) % COLS]);
                        end
                    end
                    grid[r][c] = old[r][c] ? (count == 2 || count == 3) : (count == 3);
                end
            end
        endfunction

        function void note_request(req_t kind, logic [5:0] col, logic [5:0] row, logic alive);
            completion_t done;
            logic        on_grid;
            on_grid    = (col < COLS) && (row < ROWS);
            done.kind  = kind;
            done.alive = 1'b0;
            case (kind)
                REQ_WRITE:
                begin
                    if (on_grid)
                        grid[row][col] = alive;
                end
                REQ_READ:
                begin
                    if (on_grid)
                        done.alive = grid[row][col];
                end
                REQ_ADVANCE:
                    step_generation();
                default:
                begin
                    foreach (grid[r])
                        grid[r] = '0;
                end
            endcase
            awaited.push_back(done);
        endfunction

        task report(string what, int wanted, int seen);
            $display("mismatch at %0t ns: %s wanted %0d saw %0d", $time, what, wanted, seen);
            mismatches++;
        endtask

        task check_completion(logic [1:0] kind_seen, logic [7:0] data_seen);
            completion_t done;
            if (awaited.size() == 0)
            begin
                report("completion word with nothing outstanding, done_type", -1,
                       int'(kind_seen));
            end
            else
            begin
                done = awaited.pop_front();
                if (kind_seen !== done.kind)
                    report("done_type", int'(done.kind), int'(kind_seen));
                if (data_seen[0] !== done.alive)
                    report("read_alive", int'(done.alive), int'(data_seen[0]));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // cell_col[5:0], cell_row[11:6], write_alive[12]
    logic [1:0]  s_axis_tuser;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // read_alive[0]
    logic [1:0]  m_axis_tuser;   // done_type[1:0]

    life_scoreboard board = new();

    int   items_sent = 0;
    bit   idling_on  = 1'b1;
    int   stall_left = 0;
    int   quiet      = 0;

    logic [5:0] origin_row;
    logic [5:0] origin_col;
    int         span;
    int         pick;

    life_grid_generation_step_unit #(
        .GRID_COLS (COLS),
        .GRID_ROWS (ROWS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // both monitors sample the values from just before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_completion(m_axis_tuser, m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                board.note_request(req_t'(s_axis_tuser), s_axis_tdata[5:0],
                                   s_axis_tdata[11:6], s_axis_tdata[12]);
        end
    end

    // receiver side: random stall bursts, none in the calm stretch
    always @(posedge clk)
    begin
        if (!idling_on)
        begin
            m_axis_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 5);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog: too many cycles in a row with no word moving on either side
    initial
    begin
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // one request word, with an optional idle burst in front of it
    task automatic send_request(input req_t kind, input logic [5:0] col,
                                input logic [5:0] row, input logic alive);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, alive, row, col};
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        idling_on = (items_sent < ITEMS - CALM_ITEMS);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // grid starts all dead
        send_request(REQ_READ, 6'd0, 6'd0, 1'b1);
        // two corners of the grid, each written alive and read back
        send_request(REQ_WRITE, 6'd0, 6'd0, 1'b1);
        send_request(REQ_READ, 6'd0, 6'd0, 1'b0);
        send_request(REQ_WRITE, 6'd63, 6'd63, 1'b1);
        send_request(REQ_READ, 6'd63, 6'd63, 1'b0);
        // four corners make a block across both wraps: a still life
        send_request(REQ_WRITE, 6'd63, 6'd0, 1'b1);
        send_request(REQ_WRITE, 6'd0, 6'd63, 1'b1);
        send_request(REQ_ADVANCE, 6'd63, 6'd63, 1'b1);
        send_request(REQ_READ, 6'd0, 6'd0, 1'b1);
        send_request(REQ_READ, 6'd63, 6'd63, 1'b1);
        // kill one corner: birth with exactly three brings it back
        send_request(REQ_WRITE, 6'd0, 6'd0, 1'b0);
        send_request(REQ_READ, 6'd0, 6'd0, 1'b1);
        send_request(REQ_ADVANCE, 6'd0, 6'd0, 1'b0);
        send_request(REQ_READ, 6'd0, 6'd0, 1'b0);
        // clear wipes everything
        send_request(REQ_CLEAR, 6'd63, 6'd63, 1'b1);
        send_request(REQ_READ, 6'd63, 6'd63, 1'b1);
        // blinker straddling the left and right edges
        send_request(REQ_WRITE, 6'd63, 6'd10, 1'b1);
        send_request(REQ_WRITE, 6'd0, 6'd10, 1'b1);
        send_request(REQ_WRITE, 6'd1, 6'd10, 1'b1);
        send_request(REQ_ADVANCE, 6'd42, 6'd21, 1'b0);
        send_request(REQ_READ, 6'd0, 6'd9, 1'b0);
        send_request(REQ_READ, 6'd0, 6'd11, 1'b1);
        send_request(REQ_READ, 6'd63, 6'd10, 1'b0);
        send_request(REQ_ADVANCE, 6'd21, 6'd42, 1'b1);
        send_request(REQ_READ, 6'd63, 6'd10, 1'b1);

        // random part: mostly seeded patterns that evolve, some noise
        while (items_sent < ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
            begin
                // small window anywhere, wrapping past the edges as coordinates overflow
                origin_row = 6'($urandom_range(0, 63));
                origin_col = 6'($urandom_range(0, 63));
                span       = $urandom_range(3, 8);
                repeat ($urandom_range(4, 16))
                    send_request(REQ_WRITE, 6'(origin_col + $urandom_range(0, span - 1)),
                                 6'(origin_row + $urandom_range(0, span - 1)),
                                 $urandom_range(0, 99) < 65);
                repeat ($urandom_range(1, 4))
                begin
                    send_request(REQ_ADVANCE, 6'($urandom_range(0, 63)),
                                 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
                    repeat ($urandom_range(2, 6))
                        send_request(REQ_READ,
                                     6'(origin_col + $urandom_range(0, span + 3) - 2),
                                     6'(origin_row + $urandom_range(0, span + 3) - 2),
                                     1'($urandom_range(0, 1)));
                end
            end
            else if (pick < 92)
            begin
                // single noise word of any kind with fully random fields
                pick = $urandom_range(0, 99);
                send_request(pick < 45 ? REQ_WRITE : pick < 85 ? REQ_READ :
                             pick < 95 ? REQ_ADVANCE : REQ_CLEAR,
                             6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                             1'($urandom_range(0, 1)));
            end
            else
            begin
                send_request(REQ_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                             1'($urandom_range(0, 1)));
                send_request(REQ_READ, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                             1'($urandom_range(0, 1)));
            end
        end
        s_axis_tvalid <= 1'b0;

        // let every completion word come home, then watch for strays
        while (board.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (board.mismatches == 0 && board.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
